### rtl/usbbot_pkg.sv
// Shared types and constants for the bulk-only mass-storage target.
// No dependencies; imported by every module of the block.
package usbbot_pkg;

   // Bytes per bulk IN packet
   localparam int PACKET_BYTES = 64;
   localparam logic [31:0] PKT_WORD = 32'(PACKET_BYTES);
   localparam logic [8:0]  PKT_OFF  = 9'(PACKET_BYTES);
   localparam logic [6:0]  PKT_LEN  = 7'(PACKET_BYTES);

   // Event codes
   localparam logic [1:0] FUNC_CMD = 2'd0;
   localparam logic [1:0] FUNC_IN  = 2'd1;
   localparam logic [1:0] FUNC_OUT = 2'd2;

   // SCSI opcodes
   localparam logic [7:0] OP_TEST_READY = 8'h00;
   localparam logic [7:0] OP_SENSE      = 8'h03;
   localparam logic [7:0] OP_INQUIRY    = 8'h12;
   localparam logic [7:0] OP_FMT_CAPS   = 8'h23;
   localparam logic [7:0] OP_CAPACITY   = 8'h25;
   localparam logic [7:0] OP_READ10     = 8'h28;
   localparam logic [7:0] OP_WRITE10    = 8'h2A;

   // Data source regions
   localparam logic [3:0] SRC_INQUIRY  = 4'd0;
   localparam logic [3:0] SRC_FMTCAP   = 4'd1;
   localparam logic [3:0] SRC_CAPACITY = 4'd2;
   localparam logic [3:0] SRC_SENSE    = 4'd3;
   localparam logic [3:0] SRC_BOOT     = 4'd4;
   localparam logic [3:0] SRC_FAT      = 4'd5;
   localparam logic [3:0] SRC_ZEROS    = 4'd6;
   localparam logic [3:0] SRC_ROOT     = 4'd7;
   localparam logic [3:0] SRC_FILE     = 4'd8;
   localparam logic [3:0] SRC_CSW      = 4'd9;
   localparam logic [3:0] SRC_PAD      = 4'd10;

   // Reply sizes
   localparam logic [31:0] INQUIRY_BYTES  = 32'd36;
   localparam logic [31:0] FMTCAP_BYTES   = 32'd12;
   localparam logic [31:0] CAPACITY_BYTES = 32'd8;
   localparam logic [31:0] SENSE_BYTES    = 32'd18;
   localparam logic [31:0] CSW_BYTES      = 32'd13;

   // Emulated disk layout (byte addresses)
   localparam logic [31:0] ADDR_BOOT     = 32'd0;
   localparam logic [31:0] ADDR_FAT0     = 32'd512;
   localparam logic [31:0] ADDR_ZERO0    = 32'd576;
   localparam logic [31:0] ADDR_FAT1     = 32'd16896;
   localparam logic [31:0] ADDR_ZERO1    = 32'd16960;
   localparam logic [31:0] ADDR_ROOT     = 32'd33280;
   localparam logic [31:0] ADDR_ZERO2    = 32'd33344;
   localparam logic [31:0] ADDR_FILE     = 32'd49664;
   localparam logic [31:0] ADDR_FILE_END = 32'd50175;

   typedef enum logic [1:0] {
      ST_COMMAND = 2'd0,
      ST_DATA    = 2'd1,
      ST_STATUS  = 2'd2
   } stage_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  opcode;
      logic [31:0] transfer_length;
      logic [31:0] lba;
      logic        direction_in;
      logic [31:0] tag;
      logic [6:0]  out_len;
   } req_type;

   typedef struct packed {
      logic [3:0]  source;
      logic [8:0]  source_offset;
      logic [6:0]  packet_length;
      logic [31:0] csw_tag;
      logic [31:0] csw_residue;
      logic        csw_status;
   } rsp_type;

   typedef struct packed {
      stage_type   stage;
      logic [31:0] send_remaining;
      logic [3:0]  current_source;
      logic [8:0]  current_offset;
      logic [31:0] byte_address;
      logic [31:0] write_remaining;
      logic [7:0]  latched_opcode;
      logic [31:0] latched_tag;
      logic [31:0] latched_residue;
      logic        latched_status;
   } state_type;

endpackage

### rtl/usb_bulk_only_scsi_target.sv
// Top level of the bulk-only mass-storage target: input, state and result registers.
// Depends on usbbot_pkg and usbbot_step.
//
// Usage:
//  - req channel carries one event per transaction: a decoded command block,
//    an IN-endpoint-ready notice or an OUT-packet-received notice.
//  - rsp channel carries the IN packet descriptor (region, offset, length and
//    status wrapper fields). An event yields zero or one descriptor.
//  - Both channels: transaction when valid is high and stall is low.
// Path: an event in the input register updates the state register and, if it
//  makes a packet, loads the result register that drives rsp, once the event advances.
// Throughput: one event per cycle unless stalled. The step logic is one pass of
//  compares and subtracts between the input, state and result registers.
// Stall: a pending result sits in the result register; the input register
//  still loads while the result register can take its successor, and req_stall
//  rises only when a held event waits on a stalled, full result register.
// Reset: stage returns to command, counters and latched wrapper fields clear,
//  the current region is the zeros region; no event or result is pending.
module usb_bulk_only_scsi_target
   import usbbot_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      in_valid_ff, in_valid_in;
   req_type   in_data_ff, in_data_in;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff, rsp_data_in;

   state_type step_state;
   rsp_type   step_rsp;
   logic      step_produced;
   logic      advance;
   logic      in_load;

   usbbot_step u_step (
      .state_cur    (state_ff),
      .req          (in_data_ff),
      .state_nxt    (step_state),
      .rsp          (step_rsp),
      .rsp_produced (step_produced)
   );

   // held event moves on whenever the result register is free or draining
   assign advance = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign in_load = ~in_valid_ff | advance;
   assign req_stall = ~in_load;

   always_comb begin
      in_valid_in = in_load ? req_valid : in_valid_ff;
      in_data_in = (in_load && req_valid) ? req_data : in_data_ff;
      state_in = advance ? step_state : state_ff;
      rsp_valid_in = advance ? step_produced : (rsp_valid_ff & rsp_stall);
      rsp_data_in = (advance && step_produced) ? step_rsp : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff.stage <= ST_COMMAND;
         state_ff.send_remaining <= '0;
         state_ff.current_source <= SRC_ZEROS;
         state_ff.current_offset <= '0;
         state_ff.byte_address <= '0;
         state_ff.write_remaining <= '0;
         state_ff.latched_opcode <= '0;
         state_ff.latched_tag <= '0;
         state_ff.latched_residue <= '0;
         state_ff.latched_status <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_cmd_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff.stage == ST_COMMAND |-> state_ff.send_remaining == '0)
      else $error("command stage with bytes still pending");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_pkt_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.packet_length <= PKT_LEN)
      else $error("packet longer than endpoint size");

   a_csw_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.source != SRC_CSW |->
         rsp_data_ff.csw_tag == '0 && rsp_data_ff.csw_residue == '0 &&
         rsp_data_ff.csw_status == 1'b0)
      else $error("wrapper fields set on a data packet");
`endif

endmodule

### rtl/usbbot_step.sv
// Transaction step logic: next state and optional IN packet descriptor for one event.
// Depends on usbbot_pkg.
module usbbot_step
   import usbbot_pkg::*;
(
   input  state_type state_cur,
   input  req_type   req,
   output state_type state_nxt,
   output rsp_type   rsp,
   output logic      rsp_produced
);

   typedef struct packed {
      logic      ok;
      rsp_type   rsp;
      state_type st;
   } send_type;

   function automatic state_type set_region(state_type s, logic [3:0] src);
      state_type r;
      r = s;
      r.current_source = src;
      r.current_offset = '0;
      return r;
   endfunction

   // Pick the region for the chunk at byte_address, then step the address
   function automatic state_type disk_map(state_type s);
      state_type   r;
      logic [31:0] a;
      r = s;
      a = s.byte_address;
      if (a == ADDR_BOOT)
         r = set_region(r, SRC_BOOT);
      else if (a == ADDR_FAT0 || a == ADDR_FAT1)
         r = set_region(r, SRC_FAT);
      else if (a == ADDR_ROOT)
         r = set_region(r, SRC_ROOT);
      else if (a == ADDR_FILE)
         r = set_region(r, SRC_FILE);
      else if ((a >= ADDR_ZERO0 && a < ADDR_FAT1) || (a >= ADDR_ZERO1 && a < ADDR_ROOT) ||
               (a >= ADDR_ZERO2 && a < ADDR_FILE) || (a > ADDR_FILE_END))
         r = set_region(r, SRC_ZEROS);
      r.byte_address = a + PKT_WORD;
      return r;
   endfunction

   function automatic state_type enter_status(state_type s);
      state_type r;
      r = set_region(s, SRC_CSW);
      r.stage = ST_STATUS;
      r.send_remaining = CSW_BYTES;
      return r;
   endfunction

   function automatic send_type send_pkt(state_type s);
      send_type  r;
      state_type t;
      t = s;
      r.ok = 1'b1;
      r.rsp = '0;
      if (t.send_remaining == '0) begin
         if (t.stage == ST_DATA)
            t = enter_status(t);
         else
            r.ok = 1'b0;
      end
      r.rsp.source = t.current_source;
      r.rsp.source_offset = t.current_offset;
      if (t.current_source == SRC_CSW) begin
         r.rsp.csw_tag = t.latched_tag;
         r.rsp.csw_residue = t.latched_residue;
         r.rsp.csw_status = t.latched_status;
      end
      if (t.send_remaining > PKT_WORD) begin
         r.rsp.packet_length = PKT_LEN;
         t.current_offset = t.current_offset + PKT_OFF;
         t.send_remaining = t.send_remaining - PKT_WORD;
         if (t.latched_opcode == OP_READ10 && t.stage == ST_DATA)
            t = disk_map(t);
      end else begin
         r.rsp.packet_length = t.send_remaining[6:0];
         t.send_remaining = '0;
         if (t.stage == ST_DATA)
            t = enter_status(t);
         else if (t.stage == ST_STATUS)
            t.stage = ST_COMMAND;
      end
      r.st = r.ok ? t : s;
      return r;
   endfunction

   function automatic state_type fixed_reply(state_type s, logic [3:0] src,
                                             logic [31:0] size, logic [31:0] tl);
      state_type r;
      r = set_region(s, src);
      r.latched_residue = (tl > size) ? tl - size : '0;
      r.latched_status = 1'b0;
      r.send_remaining = (tl > size) ? size : tl;
      return r;
   endfunction

   state_type   s;
   send_type    sr;
   logic        do_send;
   logic [31:0] olen;
   logic [31:0] wr_next;
   logic [31:0] pad_len;

   always_comb begin
      s = state_cur;
      do_send = 1'b0;
      olen = {25'd0, req.out_len};
      if (olen > PKT_WORD)
         olen = PKT_WORD;
      wr_next = state_cur.write_remaining - olen;
      pad_len = {31'd0, req.direction_in};
      unique case (req.func)
         FUNC_CMD: begin
            s.stage = ST_DATA;
            s.latched_opcode = req.opcode;
            s.latched_tag = req.tag;
            do_send = 1'b1;
            unique case (req.opcode)
               OP_INQUIRY:
                  s = fixed_reply(s, SRC_INQUIRY, INQUIRY_BYTES, req.transfer_length);
               OP_FMT_CAPS:
                  s = fixed_reply(s, SRC_FMTCAP, FMTCAP_BYTES, req.transfer_length);
               OP_CAPACITY:
                  s = fixed_reply(s, SRC_CAPACITY, CAPACITY_BYTES, req.transfer_length);
               OP_SENSE:
                  s = fixed_reply(s, SRC_SENSE, SENSE_BYTES, req.transfer_length);
               OP_READ10: begin
                  s.send_remaining = req.transfer_length;
                  s.byte_address = {req.lba[22:0], 9'd0};
                  s.latched_residue = '0;
                  s.latched_status = 1'b0;
                  s = disk_map(s);
               end
               OP_WRITE10: begin
                  s.write_remaining = req.transfer_length;
                  s.latched_residue = '0;
                  s.latched_status = 1'b0;
                  do_send = 1'b0;
               end
               OP_TEST_READY: begin
                  s.send_remaining = '0;
                  s.latched_residue = '0;
                  s.latched_status = 1'b0;
               end
               default: begin
                  // unsupported command: fail, one pad byte if host expects data
                  s.send_remaining = pad_len;
                  if (req.direction_in)
                     s = set_region(s, SRC_PAD);
                  s.latched_residue = (req.transfer_length > pad_len) ?
                                      req.transfer_length - pad_len : '0;
                  s.latched_status = 1'b1;
               end
            endcase
         end
         FUNC_IN:
            do_send = 1'b1;
         FUNC_OUT: begin
            s.write_remaining = wr_next;
            if (wr_next == '0) begin
               s.send_remaining = '0;
               do_send = 1'b1;
            end
         end
         default: ;
      endcase
      sr = send_pkt(s);
      if (do_send) begin
         state_nxt = sr.st;
         rsp = sr.rsp;
         rsp_produced = sr.ok;
      end else begin
         state_nxt = s;
         rsp = sr.rsp;
         rsp_produced = 1'b0;
      end
   end

endmodule
